@@ src/cbti_pkg.sv @@
// shared types, constants and helpers for the custom-base text to integer block
`default_nettype none

package cbti_pkg;

  // fixed field widths
  localparam int CH_W      = 8;
  localparam int BASE_W    = 5;
  localparam int CFG_W     = 64;
  localparam int OUT_W     = 32;
  localparam int NUM_SLOTS = 16;
  localparam int SYM_IDX_W = 4;

  // parameter defaults
  localparam int MAX_SYMBOLS_DEF = 16;
  localparam int VALUE_BITS_DEF  = 32;

  // character codes
  localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_DEL   = 8'h7F;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_ALPHA_LO = 2'd0,
    REG_ALPHA_HI = 2'd1,
    REG_RADIX    = 2'd2
  } cfg_reg_t;

  // parse phase, one-hot
  typedef enum logic [3:0] {
    PH_SPACE = 4'b0001,
    PH_SIGN  = 4'b0010,
    PH_DIGIT = 4'b0100,
    PH_DONE  = 4'b1000
  } phase_t;

  // alphabet, symbol 0 in the lowest byte
  typedef logic [NUM_SLOTS-1:0][CH_W-1:0] sym_arr_t;

  // digit lookup result
  typedef struct packed {
    logic                 hit;
    logic [SYM_IDX_W-1:0] idx;
  } match_t;

  function automatic logic is_white(input logic [CH_W-1:0] c);
    return c inside {CH_SPACE, [CH_TAB:CH_CR]};
  endfunction

  function automatic logic is_sign(input logic [CH_W-1:0] c);
    return c inside {CH_PLUS, CH_MINUS};
  endfunction

  // bytes that may not serve as digit symbols
  function automatic logic is_bad_symbol(input logic [CH_W-1:0] c);
    return c inside {[CH_NUL:CH_SPACE], CH_PLUS, CH_MINUS, CH_DEL};
  endfunction

endpackage

`default_nettype wire

@@ src/cbti_alpha_check.sv @@
// registered validity check of the configured digit alphabet
`default_nettype none

module cbti_alpha_check
  import cbti_pkg::*;
#(
  parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire sym_arr_t          syms,
  input  wire logic [BASE_W-1:0] radix,
  output logic                   alpha_ok_r
);

  logic alpha_ok_nxt;

  // length bounds, bad symbols and repeated symbols among those in use
  always_comb begin
    alpha_ok_nxt = (radix >= BASE_W'(2)) && (radix <= BASE_W'(MAX_SYMBOLS));
    for (int i = 0; i < MAX_SYMBOLS; i++) begin
      if (BASE_W'(i) < radix) begin
        if (is_bad_symbol(syms[i])) begin
          alpha_ok_nxt = 1'b0;
        end
        for (int j = i + 1; j < MAX_SYMBOLS; j++) begin
          if ((BASE_W'(j) < radix) && (syms[j] == syms[i])) begin
            alpha_ok_nxt = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_ok_r <= 1'b0;
    end else begin
      alpha_ok_r <= alpha_ok_nxt;
    end
  end

endmodule

`default_nettype wire

@@ src/cbti_symbol_match.sv @@
// maps a character to its position in the digit alphabet
`default_nettype none

module cbti_symbol_match
  import cbti_pkg::*;
#(
  parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF
) (
  input  wire logic [CH_W-1:0]   ch,
  input  wire sym_arr_t          syms,
  input  wire logic [BASE_W-1:0] radix,
  output match_t                 match
);

  // compare against every lane in use, lowest position wins
  always_comb begin
    match.hit = 1'b0;
    match.idx = '0;
    for (int i = MAX_SYMBOLS - 1; i >= 0; i--) begin
      if ((BASE_W'(i) < radix) && (syms[i] == ch) && (ch != CH_NUL)) begin
        match.hit = 1'b1;
        match.idx = SYM_IDX_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

@@ src/custom_base_text_to_integer.sv @@
// top level of the custom-base text to integer block
//
//   port group   dir   handshake               payload
//   in_          in    in_valid / in_ready     in_ch, in_first
//   out_         out   out_valid / out_ready   out_value, out_finished
//   cfg_         in    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// one word per cycle sustained while the output is not stalled; each word passes
// through the input register, then through the per-character update into the
// result register. the accumulate step (times base plus digit) closes the loop.
// a stalled output holds both stages; the input register takes a new word
// whenever the output register frees up. reset clears the parse to a fresh string
// and the alphabet registers to zero. cfg_ready is always high.
`default_nettype none

module custom_base_text_to_integer
  import cbti_pkg::*;
#(
  parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
  parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [CH_W-1:0]         in_ch,
  input  wire logic                    in_first,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic signed [OUT_W-1:0]      out_value,
  output logic                         out_finished,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [1:0]              cfg_index,
  input  wire logic [CFG_W-1:0]        cfg_data
);

  // configuration
  logic [CFG_W-1:0]  alpha_lo_r;
  logic [CFG_W-1:0]  alpha_hi_r;
  logic [BASE_W-1:0] radix_r;
  sym_arr_t          syms;
  logic              alpha_ok_r;

  // input stage
  logic              s1_valid_r, s1_valid_nxt;
  logic [CH_W-1:0]   s1_ch_r;
  logic              s1_first_r;

  // parse state
  phase_t                  phase_r, phase_nxt, ph_base;
  logic                    neg_r, neg_nxt, neg_base;
  logic [VALUE_BITS-1:0]   acc_r, acc_nxt, acc_base, acc_step;
  logic signed [VALUE_BITS-1:0] signed_val;

  // result stage
  logic                    out_valid_r, out_valid_nxt;
  logic signed [OUT_W-1:0] out_value_r, out_value_nxt;
  logic                    out_finished_r, out_finished_nxt;

  logic   adv;
  logic   fire;
  match_t match;

  assign cfg_ready = 1'b1;
  assign syms      = {alpha_hi_r, alpha_lo_r};

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_lo_r <= '0;
      alpha_hi_r <= '0;
      radix_r    <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ALPHA_LO: alpha_lo_r <= cfg_data;
        REG_ALPHA_HI: alpha_hi_r <= cfg_data;
        REG_RADIX:    radix_r    <= cfg_data[BASE_W-1:0];
        default:      ;
      endcase
    end
  end

  cbti_alpha_check #(
    .MAX_SYMBOLS(MAX_SYMBOLS)
  ) u_alpha_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .syms      (syms),
    .radix     (radix_r),
    .alpha_ok_r(alpha_ok_r)
  );

  cbti_symbol_match #(
    .MAX_SYMBOLS(MAX_SYMBOLS)
  ) u_symbol_match (
    .ch      (s1_ch_r),
    .syms    (syms),
    .radix   (radix_r),
    .match   (match)
  );

  // flow control
  assign adv      = !out_valid_r || out_ready;
  assign fire     = s1_valid_r && adv;
  assign in_ready = !s1_valid_r || adv;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_ch_r    <= in_ch;
      s1_first_r <= in_first;
    end
  end

  // per-character update
  always_comb begin
    ph_base  = s1_first_r ? PH_SPACE : phase_r;
    neg_base = s1_first_r ? 1'b0 : neg_r;
    acc_base = s1_first_r ? '0 : acc_r;
    acc_step = VALUE_BITS'(acc_base * VALUE_BITS'(radix_r)) + VALUE_BITS'(match.idx);

    phase_nxt        = phase_r;
    neg_nxt          = neg_r;
    acc_nxt          = acc_r;
    out_value_nxt    = out_value_r;
    out_finished_nxt = out_finished_r;
    signed_val       = '0;

    if (fire) begin
      phase_nxt = ph_base;
      neg_nxt   = neg_base;
      acc_nxt   = acc_base;
      if (!alpha_ok_r) begin
        phase_nxt = PH_DONE;
      end else if ((ph_base == PH_SPACE) && is_white(s1_ch_r)) begin
        phase_nxt = PH_SPACE;
      end else if (((ph_base == PH_SPACE) || (ph_base == PH_SIGN)) && is_sign(s1_ch_r)) begin
        phase_nxt = PH_SIGN;
        if (s1_ch_r == CH_MINUS) begin
          neg_nxt = !neg_base;
        end
      end else if (ph_base != PH_DONE) begin
        if (match.hit) begin
          phase_nxt = PH_DIGIT;
          acc_nxt   = acc_step;
        end else begin
          phase_nxt = PH_DONE;
        end
      end

      // apply sign, then sign-extend or truncate to the result width
      signed_val       = neg_nxt ? (~acc_nxt + 1'b1) : acc_nxt;
      out_value_nxt    = alpha_ok_r ? OUT_W'(signed_val) : '0;
      out_finished_nxt = (phase_nxt == PH_DONE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SPACE;
      neg_r   <= 1'b0;
      acc_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      neg_r   <= neg_nxt;
      acc_r   <= acc_nxt;
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r    <= out_value_nxt;
    out_finished_r <= out_finished_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_value    = out_value_r;
  assign out_finished = out_finished_r;

`ifndef ASSERT_OFF
  // a bad alphabet yields a zero, finished word
  a_bad_alpha_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && fire && !alpha_ok_r) |=> (out_value == '0 && out_finished))
    else $error("bad alphabet did not give a zero finished word");

  // a stopped parse stays stopped until a new string starts
  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && phase_r == PH_DONE && !(fire && s1_first_r)) |=> (phase_r == PH_DONE))
    else $error("parse left the stopped phase without a new string");

  // the finished flag matches the phase left by the same word
  a_finished_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && fire) |=> (out_finished == (phase_r == PH_DONE)))
    else $error("finished flag disagrees with parse phase");

  // the accumulator only moves when a word is processed
  a_acc_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !fire) |=> ($stable(acc_r) && $stable(neg_r)))
    else $error("parse state changed with no word processed");
`endif

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// testbench for the custom-base text to integer block: directed and random strings
`timescale 1ns / 100ps

module tb_top
  import cbti_pkg::*;
();

  localparam int          RESET_CYCLES = 9;
  localparam int          DRAIN_CYCLES = 4;
  localparam int          STALL_LIMIT  = 2000;
  localparam int          RANDOM_ITEMS = 1050;
  localparam logic [1:0]  REG_SPARE    = 2'd3;

  // decimal alphabet "0".."9" and a 16-symbol alphabet of high bytes
  localparam logic [63:0] DEC_LO = 64'h3736_3534_3332_3130;
  localparam logic [63:0] DEC_HI = 64'h0000_0000_0000_3938;
  localparam logic [63:0] TOP_LO = 64'hF7F6_F5F4_F3F2_F1F0;
  localparam logic [63:0] TOP_HI = 64'hFFFE_FDFC_FBFA_F9F8;

  typedef struct packed {
    logic [OUT_W-1:0] value;
    logic             finished;
  } parse_t;

  logic               clk          = 1'b0;
  logic               rst_n        = 1'b0;
  logic               in_valid     = 1'b0;
  logic [CH_W-1:0]    in_ch        = '0;
  logic               in_first     = 1'b0;
  logic               out_ready    = 1'b0;
  logic               cfg_valid    = 1'b0;
  logic [1:0]         cfg_index    = '0;
  logic [CFG_W-1:0]   cfg_data     = '0;
  logic               in_ready;
  logic               out_valid;
  logic signed [OUT_W-1:0] out_value;
  logic               out_finished;
  logic               cfg_ready;

  // parser state mirrored by the predictor
  logic [2*CFG_W-1:0] alpha_tab    = '0;
  logic [BASE_W-1:0]  radix        = '0;
  phase_t             ph           = PH_SPACE;
  logic               neg          = 1'b0;
  logic [OUT_W-1:0]   acc          = '0;
  parse_t             parsed_q[$];

  // alphabet currently loaded, as seen by the stimulus
  logic [2*CFG_W-1:0] stim_tab     = '0;
  logic [BASE_W-1:0]  stim_len     = '0;

  bit                 in_idle      = 1'b1;
  bit                 out_idle     = 1'b1;
  int                 chars_sent   = 0;
  int                 mismatches   = 0;
  int                 quiet_cycles = 0;

  always #6 clk = ~clk;

  custom_base_text_to_integer #(
    .MAX_SYMBOLS (MAX_SYMBOLS_DEF),
    .VALUE_BITS  (VALUE_BITS_DEF)
  ) u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_ch        (in_ch),
    .in_first     (in_first),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_value    (out_value),
    .out_finished (out_finished),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // alphabet usable: enough symbols, no repeats, no blank, sign or control bytes
  function automatic bit alphabet_ok();
    logic [CH_W-1:0] s;
    if (radix < 2 || radix > MAX_SYMBOLS_DEF) return 1'b0;
    for (int i = 0; i < radix; i++) begin
      s = alpha_tab[i*CH_W +: CH_W];
      if (s <= CH_SPACE || s == CH_PLUS || s == CH_MINUS || s == CH_DEL) return 1'b0;
      for (int j = i + 1; j < radix; j++)
        if (alpha_tab[j*CH_W +: CH_W] == s) return 1'b0;
    end
    return 1'b1;
  endfunction

  // position of a byte in the alphabet, -1 when it is no digit
  function automatic int digit_of(input logic [CH_W-1:0] c);
    for (int i = 0; i < radix && i < NUM_SLOTS; i++)
      if (alpha_tab[i*CH_W +: CH_W] == c) return i;
    return -1;
  endfunction

  // one character through the parser, queue the value it leaves
  task automatic parse_char(input logic [CH_W-1:0] c, input logic f);
    int     d;
    parse_t r;
    if (f) begin
      ph  = PH_SPACE;
      neg = 1'b0;
      acc = '0;
    end
    if (!alphabet_ok()) begin
      ph         = PH_DONE;
      r.value    = '0;
      r.finished = 1'b1;
    end else begin
      if (ph == PH_SPACE && (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
        // leading blanks skipped
      end else if ((ph == PH_SPACE || ph == PH_SIGN) && (c == CH_PLUS || c == CH_MINUS)) begin
        ph = PH_SIGN;
        if (c == CH_MINUS) neg = ~neg;
      end else if (ph != PH_DONE) begin
        d = (c == CH_NUL) ? -1 : digit_of(c);
        if (d >= 0) begin
          ph  = PH_DIGIT;
          acc = acc * OUT_W'(radix) + OUT_W'(d);
        end else begin
          ph = PH_DONE;
        end
      end
      r.value    = neg ? OUT_W'(-acc) : acc;
      r.finished = (ph == PH_DONE);
    end
    parsed_q.push_back(r);
  endtask

  // result check, then prediction of accepted words and register writes
  always @(posedge clk) begin : check_and_predict
    parse_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (parsed_q.size() == 0) begin
          $error("unexpected word: value %0d finished %0b", out_value, out_finished);
          mismatches++;
        end else begin
          want = parsed_q.pop_front();
          if (out_value !== want.value) begin
            $error("value: expected %0d, got %0d", $signed(want.value), out_value);
            mismatches++;
          end
          if (out_finished !== want.finished) begin
            $error("finished: expected %0b, got %0b", want.finished, out_finished);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) parse_char(in_ch, in_first);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ALPHA_LO: alpha_tab[CFG_W-1:0]       = cfg_data;
          REG_ALPHA_HI: alpha_tab[2*CFG_W-1:CFG_W] = cfg_data;
          REG_RADIX:    radix                      = cfg_data[BASE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // watchdog on cycles with no word moving anywhere
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side back-pressure, one draw per word
  initial begin : drive_out_ready
    int stall;
    wait (rst_n === 1'b1);
    forever begin
      stall = out_idle ? $urandom_range(0, 15) : 0;
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // one character word, after a random gap
  task automatic send_char(input logic [CH_W-1:0] c, input logic f);
    int gap;
    gap = in_idle ? $urandom_range(0, 15) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_ch    <= c;
    in_first <= f;
    do @(posedge clk); while (!in_ready);
    chars_sent++;
  endtask

  // stop sending and wait until every result is back
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (parsed_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // program all three registers; spare high bits of the base word are noise
  task automatic load_alphabet(input logic [2*CFG_W-1:0] tab, input logic [BASE_W-1:0] len);
    logic [CFG_W-1:0] pad;
    pad = {$urandom, $urandom};
    settle();
    write_reg(REG_ALPHA_LO, tab[CFG_W-1:0]);
    write_reg(REG_ALPHA_HI, tab[2*CFG_W-1:CFG_W]);
    write_reg(REG_RADIX, {pad[CFG_W-1:BASE_W], len});
    stim_tab = tab;
    stim_len = len;
  endtask

  // random alphabet, mostly usable, sometimes broken in one way
  task automatic make_alphabet(output logic [2*CFG_W-1:0] tab, output logic [BASE_W-1:0] len);
    logic [CH_W-1:0] s;
    int              pick;
    int              k;
    bit              clash;
    pick = $urandom_range(0, 19);
    case (pick)
      0:       len = 2;
      1, 2:    len = 16;
      default: len = BASE_W'($urandom_range(2, 16));
    endcase
    for (int i = 0; i < NUM_SLOTS; i++) tab[i*CH_W +: CH_W] = CH_W'($urandom);
    for (int i = 0; i < len; i++) begin
      do begin
        s     = CH_W'($urandom_range(33, 255));
        clash = (s == CH_PLUS || s == CH_MINUS || s == CH_DEL);
        for (int j = 0; j < i; j++)
          if (tab[j*CH_W +: CH_W] == s) clash = 1'b1;
      end while (clash);
      tab[i*CH_W +: CH_W] = s;
    end
    case (pick)
      17: len = BASE_W'($urandom_range(0, 1));
      18: len = BASE_W'($urandom_range(17, 31));
      19: begin
        k = $urandom_range(1, len - 1);
        if ($urandom_range(0, 1)) begin
          tab[k*CH_W +: CH_W] = tab[$urandom_range(0, k - 1)*CH_W +: CH_W];
        end else begin
          case ($urandom_range(0, 3))
            0:       s = CH_W'($urandom_range(0, 32));
            1:       s = CH_PLUS;
            2:       s = CH_MINUS;
            default: s = CH_DEL;
          endcase
          tab[k*CH_W +: CH_W] = s;
        end
      end
      default: ;
    endcase
  endtask

  // one string: mostly well formed, some noise and sign-then-blank cases
  task automatic send_string();
    int              kind;
    int              dl;
    int              n;
    logic            fl;
    logic [CH_W-1:0] c;
    kind = $urandom_range(0, 19);
    fl   = ($urandom_range(0, 9) != 0);
    if (kind == 0) begin
      repeat ($urandom_range(1, 6)) send_char(CH_W'($urandom), 1'($urandom_range(0, 1)));
    end else begin
      repeat ($urandom_range(0, 3)) begin
        c = ($urandom_range(0, 5) == 0) ? CH_SPACE : CH_W'($urandom_range(CH_TAB, CH_CR));
        send_char(c, fl);
        fl = 1'b0;
      end
      repeat ($urandom_range(0, 3)) begin
        send_char($urandom_range(0, 1) ? CH_PLUS : CH_MINUS, fl);
        fl = 1'b0;
      end
      if (kind == 1) begin
        send_char(CH_SPACE, fl);
        fl = 1'b0;
      end
      dl = (stim_len > NUM_SLOTS) ? NUM_SLOTS : stim_len;
      n  = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 14) : $urandom_range(0, 8);
      if (dl > 0) begin
        repeat (n) begin
          send_char(stim_tab[$urandom_range(0, dl - 1)*CH_W +: CH_W], fl);
          fl = 1'b0;
        end
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: send_char(CH_NUL, fl);
        5, 6, 7:       send_char(CH_W'($urandom), fl);
        default:       ;
      endcase
      repeat ($urandom_range(0, 2)) send_char(CH_W'($urandom), 1'b0);
    end
  endtask

  // parse starts fresh out of reset, no first flag needed; bytes after the stop are ignored
  task automatic test_fresh_after_reset();
    load_alphabet({DEC_HI, DEC_LO}, 10);
    send_char(CH_SPACE, 1'b0);
    send_char(CH_MINUS, 1'b0);
    send_char("4", 1'b0);
    send_char("2", 1'b0);
    send_char(CH_NUL, 1'b0);
    send_char("x", 1'b0);
  endtask

  // sign runs flip per minus; blank after a sign or a digit stops the parse
  task automatic test_sign_rules();
    send_char(CH_TAB, 1'b1);
    send_char(CH_MINUS, 1'b0);
    send_char(CH_PLUS, 1'b0);
    send_char(CH_MINUS, 1'b0);
    send_char("7", 1'b0);
    send_char(CH_CR, 1'b0);
    send_char(CH_MINUS, 1'b1);
    send_char(CH_SPACE, 1'b0);
  endtask

  // widest base, top byte as digit, NUL as the whole string, high non-digit
  task automatic test_field_extremes();
    load_alphabet({TOP_HI, TOP_LO}, 16);
    send_char(CH_NUL, 1'b1);
    send_char(8'hFF, 1'b1);
    send_char(8'hF0, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(8'h80, 1'b0);
    send_char(8'hFF, 1'b0);
  endtask

  // unusable alphabets zero the result; recovery needs a fresh string
  task automatic test_invalid_alphabets();
    load_alphabet({DEC_HI, DEC_LO}, 1);
    send_char("0", 1'b1);
    load_alphabet({TOP_HI, TOP_LO}, 17);
    send_char(8'hF0, 1'b1);
    load_alphabet({DEC_HI, 64'h3736_3534_3132_3130}, 10);
    send_char("1", 1'b1);
    load_alphabet({64'h0000_0000_0000_2D38, DEC_LO}, 10);
    send_char("8", 1'b1);
    load_alphabet({DEC_HI, DEC_LO}, 10);
    send_char("5", 1'b0);
    send_char("7", 1'b1);
  endtask

  // phases of random strings, most with a fresh alphabet, each with its own idle pattern
  task automatic test_random_strings();
    logic [2*CFG_W-1:0] tab;
    logic [BASE_W-1:0]  len;
    int                 stop_at;
    int                 phase_end;
    stop_at = chars_sent + RANDOM_ITEMS;
    while (chars_sent < stop_at) begin
      if ($urandom_range(0, 3) != 0) begin
        make_alphabet(tab, len);
        if ($urandom_range(0, 9) == 0) begin
          settle();
          write_reg(REG_SPARE, {$urandom, $urandom});
        end
        load_alphabet(tab, len);
      end
      in_idle   = ($urandom_range(0, 3) != 0);
      out_idle  = ($urandom_range(0, 3) != 0);
      phase_end = chars_sent + $urandom_range(20, 80);
      while (chars_sent < phase_end && chars_sent < stop_at) send_string();
    end
  endtask

  // reset, tests in turn, then drain and report
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_fresh_after_reset();
    test_sign_rules();
    test_field_extremes();
    test_invalid_alphabets();
    test_random_strings();
    settle();
    if (mismatches == 0 && parsed_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
